/* src/lrs_pkg.sv */
// shared constants, types and command codes for the logarithm unit
package lrs_pkg;

    localparam int IN_W            = 32;
    localparam int OUT_W           = 29;
    localparam int SERIES_TERMS    = 84;
    localparam int INPUT_FRAC_BITS = 16;

    localparam int WORK_FRAC = 40;
    localparam int OUT_FRAC  = 24;
    localparam int OUT_SHIFT = WORK_FRAC - OUT_FRAC;

    localparam int A_W       = 64;
    localparam int B_W       = 42;
    localparam int MUL_DIGIT = 16;
    localparam int MUL_STEPS = A_W / MUL_DIGIT;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int PP_W      = MUL_DIGIT + B_W;
    localparam int MSUM_W    = PP_W + 1;
    localparam int ACC_W     = MSUM_W - MUL_DIGIT;

    localparam int DIV_W     = WORK_FRAC;
    localparam int DIV_DIGIT = 8;
    localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int TERM_W = 8;
    localparam int CNT_W  = 7;
    localparam int SUM_W  = 50;
    localparam int RND_W  = SUM_W + 1 - OUT_SHIFT;

    localparam logic [A_W-1:0] K_ONE    = A_W'(1) << WORK_FRAC;
    localparam logic [B_W-1:0] K_E      = B_W'(64'h2B7E151628B);
    localparam logic [B_W-1:0] K_INV_E  = B_W'(64'h5E2D58D8B4);
    localparam logic [B_W-1:0] K_LOG10E = B_W'(64'h6F2DEC549C);
    localparam logic [A_W-1:0] K_HIGH   = A_W'(64'd1869169767219);
    localparam logic [A_W-1:0] K_LOW    = A_W'(64'd329853488333);

    localparam logic [OUT_W-1:0] OUT_MAX     = OUT_W'(29'h0FFFFFFF);
    localparam logic [RND_W-1:0] OUT_POS_LIM = RND_W'(29'h0FFFFFFF);
    localparam logic [RND_W-1:0] OUT_NEG_LIM = RND_W'(29'h10000000);

    localparam logic [1:0] MS_INV_E = 2'd0;
    localparam logic [1:0] MS_E     = 2'd1;
    localparam logic [1:0] MS_POW   = 2'd2;
    localparam logic [1:0] MS_LOG   = 2'd3;

    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       div_start;
        logic       red_up;
        logic       red_dn;
        logic       series_init;
        logic       term_acc;
        logic       total;
        logic       mag_scale;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic mode;
        logic a_gt_high;
        logic a_lt_low;
        logic i_last;
        logic mul_busy;
        logic div_busy;
    } t_status;

endpackage

/* src/logarithm_range_reduced_series.sv */
// top level: natural or base-10 logarithm of a Q16.16 operand, result in Q4.24
// run time grows with the range-reduction steps (at most 11 for Q16.16) and the series terms,
//   plus a scaling multiply in base-10 mode; a zero operand goes straight to the output state
// the series term time is set by the 5-step radix-256 divider running beside the multiplier
// one item at a time: start is taken again in the cycle that o_valid is high
// synchronous active-low reset idles the controller and clears the result strobe
module logarithm_range_reduced_series #(
    parameter int SERIES_TERMS    = lrs_pkg::SERIES_TERMS,
    parameter int INPUT_FRAC_BITS = lrs_pkg::INPUT_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [lrs_pkg::IN_W-1:0]         i_value,
    input  logic                             i_mode,
    output logic                             o_valid,
    output logic signed [lrs_pkg::OUT_W-1:0] o_log_value,
    output logic                             o_invalid
);

    lrs_pkg::t_cmd    cmd;
    lrs_pkg::t_status status;

    lrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    lrs_datapath #(
        .SERIES_TERMS    (SERIES_TERMS),
        .INPUT_FRAC_BITS (INPUT_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_mode      (i_mode),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_log_value (o_log_value),
        .o_invalid   (o_invalid)
    );

`ifndef SYNTHESIS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without an item in flight");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !status.mul_busy && !status.div_busy)
        else $error("arithmetic unit still running while idle");

    a_invalid_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_log_value == lrs_pkg::OUT_MAX)
        else $error("zero operand result not saturated");
`endif

endmodule

/* src/lrs_mul.sv */
// multi-cycle 64 x 42 multiplier returning the product shifted right by the work fraction
module lrs_mul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lrs_pkg::A_W-1:0]   i_a,
    input  logic [lrs_pkg::B_W-1:0]   i_b,
    output logic                      o_busy,
    output logic [lrs_pkg::A_W-1:0]   o_prod
);

    logic                          r_busy;
    logic [lrs_pkg::MUL_CNT_W-1:0] r_cnt;
    logic [lrs_pkg::A_W-1:0]       r_a;
    logic [lrs_pkg::B_W-1:0]       r_b;
    logic [lrs_pkg::ACC_W-1:0]     r_acc;
    logic [lrs_pkg::A_W-1:0]       r_lo;
    logic [lrs_pkg::PP_W-1:0]      pp;
    logic [lrs_pkg::MSUM_W-1:0]    msum;

    assign pp   = r_a[lrs_pkg::MUL_DIGIT-1:0] * r_b;
    assign msum = lrs_pkg::MSUM_W'(r_acc) + lrs_pkg::MSUM_W'(pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == lrs_pkg::MUL_CNT_W'(lrs_pkg::MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            r_a   <= r_a >> lrs_pkg::MUL_DIGIT;
            r_acc <= msum[lrs_pkg::MSUM_W-1:lrs_pkg::MUL_DIGIT];
            r_lo  <= {msum[lrs_pkg::MUL_DIGIT-1:0],
                      r_lo[lrs_pkg::A_W-1:lrs_pkg::MUL_DIGIT]};
        end
    end

    assign o_busy = r_busy;
    assign o_prod = {r_acc[lrs_pkg::WORK_FRAC-1:0],
                     r_lo[lrs_pkg::A_W-1:lrs_pkg::WORK_FRAC]};

endmodule

/* src/lrs_div.sv */
// radix-256 restoring divider for the series term by its index
module lrs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lrs_pkg::DIV_W-1:0]  i_num,
    input  logic [lrs_pkg::TERM_W-1:0] i_den,
    output logic                       o_busy,
    output logic [lrs_pkg::DIV_W-1:0]  o_quot
);

    logic                          r_busy;
    logic [lrs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [lrs_pkg::DIV_W-1:0]     r_num;
    logic [lrs_pkg::DIV_W-1:0]     r_quot;
    logic [lrs_pkg::TERM_W-1:0]    r_rem;
    logic [lrs_pkg::TERM_W-1:0]    r_den;

    logic [lrs_pkg::TERM_W-1:0]    rem_chain [0:lrs_pkg::DIV_DIGIT];
    logic [lrs_pkg::TERM_W:0]      trial     [0:lrs_pkg::DIV_DIGIT-1];
    logic [lrs_pkg::DIV_DIGIT-1:0] q_digit;

    always_comb begin
        rem_chain[0] = r_rem;
        for (int k = 0; k < lrs_pkg::DIV_DIGIT; k++) begin
            trial[k] = {rem_chain[k], r_num[lrs_pkg::DIV_W-1-k]};
            if (trial[k] >= {1'b0, r_den}) begin
                rem_chain[k+1] = lrs_pkg::TERM_W'(trial[k] - {1'b0, r_den});
                q_digit[lrs_pkg::DIV_DIGIT-1-k] = 1'b1;
            end else begin
                rem_chain[k+1] = lrs_pkg::TERM_W'(trial[k]);
                q_digit[lrs_pkg::DIV_DIGIT-1-k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == lrs_pkg::DIV_CNT_W'(lrs_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= r_num << lrs_pkg::DIV_DIGIT;
            r_rem  <= rem_chain[lrs_pkg::DIV_DIGIT];
            r_quot <= {r_quot[lrs_pkg::DIV_W-lrs_pkg::DIV_DIGIT-1:0], q_digit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* src/lrs_datapath.sv */
// datapath: reduction value, series accumulator, shared multiplier, series divider, output stage
module lrs_datapath #(
    parameter int SERIES_TERMS    = lrs_pkg::SERIES_TERMS,
    parameter int INPUT_FRAC_BITS = lrs_pkg::INPUT_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [lrs_pkg::IN_W-1:0]         i_value,
    input  logic                             i_mode,
    input  lrs_pkg::t_cmd                    i_cmd,
    output lrs_pkg::t_status                 o_status,
    output logic                             o_valid,
    output logic signed [lrs_pkg::OUT_W-1:0] o_log_value,
    output logic                             o_invalid
);

    localparam int IN_SHIFT = lrs_pkg::WORK_FRAC - INPUT_FRAC_BITS;
    localparam logic [lrs_pkg::SUM_W:0] RND_HALF =
        (lrs_pkg::SUM_W+1)'(1) << (lrs_pkg::OUT_SHIFT - 1);

    logic [lrs_pkg::A_W-1:0]            r_a;
    logic signed [lrs_pkg::CNT_W-1:0]   r_count;
    logic                               r_mode;
    logic                               r_zero;
    logic                               r_tneg;
    logic [lrs_pkg::DIV_W-1:0]          r_tmag;
    logic [lrs_pkg::DIV_W-1:0]          r_pw;
    logic [lrs_pkg::TERM_W-1:0]         r_i;
    logic signed [lrs_pkg::SUM_W-1:0]   r_sum;
    logic                               r_neg;
    logic [lrs_pkg::SUM_W-1:0]          r_mag;
    logic                               r_valid;
    logic signed [lrs_pkg::OUT_W-1:0]   r_out;
    logic                               r_inv;

    logic [lrs_pkg::A_W-1:0]            mul_a;
    logic [lrs_pkg::B_W-1:0]            mul_b;
    logic [lrs_pkg::A_W-1:0]            prod;
    logic                               mul_busy;
    logic [lrs_pkg::DIV_W-1:0]          quot;
    logic                               div_busy;
    logic                               a_below_one;
    logic                               term_neg;
    logic signed [lrs_pkg::SUM_W-1:0]   term;
    logic signed [lrs_pkg::SUM_W-1:0]   total;
    logic [lrs_pkg::SUM_W:0]            rnd_sum;
    logic [lrs_pkg::RND_W-1:0]          rnd;
    logic signed [lrs_pkg::OUT_W-1:0]   n_out;

    always_comb begin
        unique case (i_cmd.mul_sel)
            lrs_pkg::MS_INV_E: begin
                mul_a = r_a;
                mul_b = lrs_pkg::K_INV_E;
            end
            lrs_pkg::MS_E: begin
                mul_a = r_a;
                mul_b = lrs_pkg::K_E;
            end
            lrs_pkg::MS_POW: begin
                mul_a = lrs_pkg::A_W'(r_pw);
                mul_b = lrs_pkg::B_W'(r_tmag);
            end
            lrs_pkg::MS_LOG: begin
                mul_a = lrs_pkg::A_W'(r_mag);
                mul_b = lrs_pkg::K_LOG10E;
            end
            default: begin
                mul_a = r_a;
                mul_b = lrs_pkg::K_INV_E;
            end
        endcase
    end

    lrs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_prod  (prod)
    );

    lrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_pw),
        .i_den   (r_i),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign a_below_one = r_a < lrs_pkg::K_ONE;
    // odd terms follow the sign of t, even terms are always subtracted
    assign term_neg    = !r_i[0] || r_tneg;
    assign term        = lrs_pkg::SUM_W'(quot);
    assign total       = r_sum + (lrs_pkg::SUM_W'(r_count) <<< lrs_pkg::WORK_FRAC);
    assign rnd_sum     = {1'b0, r_mag} + RND_HALF;
    assign rnd         = rnd_sum[lrs_pkg::SUM_W:lrs_pkg::OUT_SHIFT];

    always_comb begin
        if (r_neg) begin
            if (rnd > lrs_pkg::OUT_NEG_LIM) begin
                n_out = lrs_pkg::OUT_W'(0) - lrs_pkg::OUT_W'(lrs_pkg::OUT_NEG_LIM);
            end else begin
                n_out = lrs_pkg::OUT_W'(0) - rnd[lrs_pkg::OUT_W-1:0];
            end
        end else if (rnd > lrs_pkg::OUT_POS_LIM) begin
            n_out = lrs_pkg::OUT_MAX;
        end else begin
            n_out = rnd[lrs_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= lrs_pkg::A_W'(i_value) << IN_SHIFT;
            r_count <= '0;
            r_mode  <= i_mode;
            r_zero  <= (i_value == '0);
        end else if (i_cmd.red_up) begin
            r_a     <= prod;
            r_count <= r_count + 1'b1;
        end else if (i_cmd.red_dn) begin
            r_a     <= prod;
            r_count <= r_count - 1'b1;
        end

        if (i_cmd.series_init) begin
            r_tneg <= a_below_one;
            r_tmag <= a_below_one ? lrs_pkg::DIV_W'(lrs_pkg::K_ONE - r_a)
                                  : lrs_pkg::DIV_W'(r_a - lrs_pkg::K_ONE);
            r_pw   <= a_below_one ? lrs_pkg::DIV_W'(lrs_pkg::K_ONE - r_a)
                                  : lrs_pkg::DIV_W'(r_a - lrs_pkg::K_ONE);
            r_i    <= lrs_pkg::TERM_W'(1);
            r_sum  <= '0;
        end else if (i_cmd.term_acc) begin
            r_sum <= term_neg ? r_sum - term : r_sum + term;
            r_pw  <= prod[lrs_pkg::DIV_W-1:0];
            r_i   <= r_i + 1'b1;
        end

        if (i_cmd.total) begin
            r_neg <= total < 0;
            r_mag <= (total < 0) ? $unsigned(-total) : $unsigned(total);
        end else if (i_cmd.mag_scale) begin
            r_mag <= prod[lrs_pkg::SUM_W-1:0];
        end

        if (i_cmd.emit) begin
            r_out <= r_zero ? lrs_pkg::OUT_MAX : n_out;
            r_inv <= r_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_comb begin
        o_status.zero      = r_zero;
        o_status.mode      = r_mode;
        o_status.a_gt_high = r_a > lrs_pkg::K_HIGH;
        o_status.a_lt_low  = r_a < lrs_pkg::K_LOW;
        o_status.i_last    = r_i == lrs_pkg::TERM_W'(SERIES_TERMS);
        o_status.mul_busy  = mul_busy;
        o_status.div_busy  = div_busy;
    end

    assign o_valid     = r_valid;
    assign o_log_value = r_out;
    assign o_invalid   = r_inv;

endmodule

/* src/lrs_ctrl.sv */
// controller state machine sequencing reduction, series, scaling and output
module lrs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lrs_pkg::t_status i_status,
    output lrs_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CHK_HI     = 4'd1;
    localparam logic [3:0] S_MUL_HI     = 4'd2;
    localparam logic [3:0] S_CHK_LO     = 4'd3;
    localparam logic [3:0] S_MUL_LO     = 4'd4;
    localparam logic [3:0] S_TERM       = 4'd5;
    localparam logic [3:0] S_TERM_WAIT  = 4'd6;
    localparam logic [3:0] S_TOTAL      = 4'd7;
    localparam logic [3:0] S_SCALE      = 4'd8;
    localparam logic [3:0] S_SCALE_WAIT = 4'd9;
    localparam logic [3:0] S_EMIT       = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK_HI;
                end
            end
            S_CHK_HI: begin
                if (i_status.zero) begin
                    n_state = S_EMIT;
                end else if (i_status.a_gt_high) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = lrs_pkg::MS_INV_E;
                    n_state         = S_MUL_HI;
                end else begin
                    n_state = S_CHK_LO;
                end
            end
            S_MUL_HI: begin
                o_cmd.mul_sel = lrs_pkg::MS_INV_E;
                if (!i_status.mul_busy) begin
                    o_cmd.red_up = 1'b1;
                    n_state      = S_CHK_HI;
                end
            end
            S_CHK_LO: begin
                if (i_status.a_lt_low) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = lrs_pkg::MS_E;
                    n_state         = S_MUL_LO;
                end else begin
                    o_cmd.series_init = 1'b1;
                    n_state           = S_TERM;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_sel = lrs_pkg::MS_E;
                if (!i_status.mul_busy) begin
                    o_cmd.red_dn = 1'b1;
                    n_state      = S_CHK_LO;
                end
            end
            S_TERM: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = lrs_pkg::MS_POW;
                o_cmd.div_start = 1'b1;
                n_state         = S_TERM_WAIT;
            end
            S_TERM_WAIT: begin
                o_cmd.mul_sel = lrs_pkg::MS_POW;
                if (!i_status.mul_busy && !i_status.div_busy) begin
                    o_cmd.term_acc = 1'b1;
                    n_state        = i_status.i_last ? S_TOTAL : S_TERM;
                end
            end
            S_TOTAL: begin
                o_cmd.total = 1'b1;
                n_state     = i_status.mode ? S_SCALE : S_EMIT;
            end
            S_SCALE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = lrs_pkg::MS_LOG;
                n_state         = S_SCALE_WAIT;
            end
            S_SCALE_WAIT: begin
                o_cmd.mul_sel = lrs_pkg::MS_LOG;
                if (!i_status.mul_busy) begin
                    o_cmd.mag_scale = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != S_IDLE;

endmodule

/* verif/log_result_checker.sv */
// result checker for the logarithm unit: predicts each item's result and compares
`timescale 1ns / 100ps
module log_result_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [lrs_pkg::IN_W-1:0]         value,
    input  logic                             mode,
    input  logic                             o_valid,
    input  logic signed [lrs_pkg::OUT_W-1:0] log_value,
    input  logic                             invalid,
    output int                               fail_count,
    output int                               pending
);

    localparam int Q_WORK = 40;
    localparam logic [63:0] Q_ONE    = 64'd1 << Q_WORK;
    localparam logic [63:0] C_E      = 64'h2B7E151628B;
    localparam logic [63:0] C_INV_E  = 64'h5E2D58D8B4;
    localparam logic [63:0] C_LOG10E = 64'h6F2DEC549C;
    localparam logic [63:0] LIM_HIGH = 64'd1869169767219;
    localparam logic [63:0] LIM_LOW  = 64'd329853488333;
    localparam logic [63:0] SAT_POS  = 64'h0FFFFFFF;
    localparam logic [63:0] SAT_NEG  = 64'h10000000;

    typedef struct packed {
        logic signed [lrs_pkg::OUT_W-1:0] log_value;
        logic                             invalid;
    } t_log_result;

    t_log_result expected_logs[$];
    int mismatches = 0;

    assign fail_count = mismatches;

    // full product, q.40 scaling, truncated
    function automatic logic [63:0] q40_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        return p[Q_WORK +: 64];
    endfunction

    function automatic t_log_result predict_log(input logic [lrs_pkg::IN_W-1:0] v,
                                                input logic md);
        logic [63:0] a, tmag, pw, mag, r;
        longint      sum, total, term;
        logic        tneg, neg, tn;
        int          steps;
        t_log_result res;
        if (v == '0) begin
            res.log_value = lrs_pkg::OUT_W'(SAT_POS);
            res.invalid   = 1'b1;
            return res;
        end
        a = 64'(v) << (Q_WORK - lrs_pkg::INPUT_FRAC_BITS);
        steps = 0;
        while (a > LIM_HIGH) begin
            a = q40_mul(a, C_INV_E);
            steps++;
        end
        while (a < LIM_LOW) begin
            a = q40_mul(a, C_E);
            steps--;
        end
        tneg = a < Q_ONE;
        tmag = tneg ? Q_ONE - a : a - Q_ONE;
        pw = tmag;
        sum = 0;
        for (int k = 1; k <= lrs_pkg::SERIES_TERMS; k++) begin
            if (k > 1) begin
                pw = q40_mul(pw, tmag);
            end
            term = longint'(pw / 64'(k));
            // alternating series, odd powers flip with a negative t
            tn = ((k % 2) == 0) != (tneg && ((k % 2) == 1));
            sum = tn ? sum - term : sum + term;
        end
        total = sum + (longint'(steps) <<< Q_WORK);
        neg = total < 0;
        mag = neg ? 64'(-total) : 64'(total);
        if (md) begin
            mag = q40_mul(mag, C_LOG10E);
        end
        r = (mag + (64'd1 << (Q_WORK - lrs_pkg::OUT_FRAC - 1))) >> (Q_WORK - lrs_pkg::OUT_FRAC);
        if (neg) begin
            if (r > SAT_NEG) begin
                r = SAT_NEG;
            end
            res.log_value = lrs_pkg::OUT_W'(64'd0 - r);
        end else begin
            if (r > SAT_POS) begin
                r = SAT_POS;
            end
            res.log_value = lrs_pkg::OUT_W'(r);
        end
        res.invalid = 1'b0;
        return res;
    endfunction

    task automatic note_mismatch(input string what, input t_log_result want,
                                 input t_log_result got);
        if (mismatches < 10) begin
            $display("%0t: %s: expected log_value %0d invalid %0b, got log_value %0d invalid %0b",
                     $realtime, what, want.log_value, want.invalid, got.log_value, got.invalid);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_log_result want, got;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                got.log_value = log_value;
                got.invalid   = invalid;
                if (expected_logs.size() == 0) begin
                    note_mismatch("result with no item pending", '0, got);
                end else begin
                    want = expected_logs.pop_front();
                    if (got.log_value !== want.log_value) begin
                        note_mismatch("log_value mismatch", want, got);
                    end else if (got.invalid !== want.invalid) begin
                        note_mismatch("invalid flag mismatch", want, got);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                expected_logs.push_back(predict_log(value, mode));
            end
        end
        pending <= expected_logs.size();
    end

endmodule

/* verif/tb.sv */
// testbench top for the logarithm unit: clock, reset, item stimulus and verdict
`timescale 1ns / 100ps
module tb;

    logic                             i_clk   = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start   = 1'b0;
    logic [lrs_pkg::IN_W-1:0]         i_value = '0;
    logic                             i_mode  = 1'b0;
    logic                             busy;
    logic                             o_valid;
    logic signed [lrs_pkg::OUT_W-1:0] o_log_value;
    logic                             o_invalid;
    int                               fail_count;
    int                               pending;
    bit                               no_gaps = 1'b0;

    localparam int N_RANDOM = 600;
    localparam int N_DIRECTED = 18;

    logic [lrs_pkg::IN_W-1:0] directed_ops[N_DIRECTED] = '{
        32'h0, 32'h0, 32'h1, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF,
        32'h10000, 32'h10000, 32'd111411, 32'd111412, 32'd19660, 32'd19661,
        32'd178145, 32'd655360, 32'h8000, 32'h80000000, 32'hFFFF, 32'h7FFFFFFF
    };

    always #2 i_clk = ~i_clk;

    logarithm_range_reduced_series DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_mode     (i_mode),
        .o_valid    (o_valid),
        .o_log_value(o_log_value),
        .o_invalid  (o_invalid)
    );

    log_result_checker u_log_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .value     (i_value),
        .mode      (i_mode),
        .o_valid   (o_valid),
        .log_value (o_log_value),
        .invalid   (o_invalid),
        .fail_count(fail_count),
        .pending   (pending)
    );

    task automatic issue(input logic [lrs_pkg::IN_W-1:0] v, input logic md);
        start   <= 1'b1;
        i_value <= v;
        i_mode  <= md;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic pause();
        int pick, gap;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 50) begin
            gap = 0;
        end else if (pick < 85) begin
            gap = $urandom_range(1, 4);
        end else if (pick < 97) begin
            gap = $urandom_range(5, 40);
        end else begin
            gap = $urandom_range(100, 900);
        end
        if (gap > 0) begin
            start   <= 1'b0;
            i_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [lrs_pkg::IN_W-1:0] pick_operand();
        logic [lrs_pkg::IN_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 3) == 0) ? '0 : lrs_pkg::IN_W'($urandom_range(1, 255));
            1, 2: v = $urandom;
            3, 4: v = $urandom >> $urandom_range(0, 31);
            5, 6: v = 32'h10000 + lrs_pkg::IN_W'($urandom_range(0, 8191)) - 32'd4096;
            // around the range-reduction thresholds
            7: v = ($urandom_range(0, 1) ? 32'd111411 : 32'd19660)
                   + lrs_pkg::IN_W'($urandom_range(0, 4)) - 32'd2;
            default: v = lrs_pkg::IN_W'($urandom_range(16384, 131072));
        endcase
        return v;
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < N_DIRECTED; k++) begin
            issue(directed_ops[k], k[0]);
            pause();
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(0, 49) == 0) begin
                no_gaps = !no_gaps;
            end
            issue(pick_operand(), 1'($urandom_range(0, 1)));
            if (k < N_RANDOM - 1) begin
                pause();
            end
        end
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
